### src/lmls_pkg.sv
package lmls_pkg;

  // Matrix geometry
  localparam int MATRIX_COLUMNS = 8;
  localparam int MATRIX_ROWS    = 8;
  localparam int PIXELS         = MATRIX_COLUMNS * MATRIX_ROWS;
  localparam int PIX_AW         = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // Rows carried by a refresh: the row field is 3 bits wide
  localparam int ROWS_SENT = (MATRIX_ROWS < 8) ? MATRIX_ROWS : 8;
  localparam logic [2:0] ROW_LAST = 3'(ROWS_SENT - 1);

  // Init sequence: 18 bytes of ones fill the 144-bit correction bank
  localparam int INIT_BYTES = 18;
  localparam logic [4:0] INIT_LAST = 5'(INIT_BYTES - 1);
  localparam logic [7:0] ALL_ONES = 8'hFF;

  // Request codes
  localparam logic [1:0] REQ_SET_PIXEL = 2'd0;
  localparam logic [1:0] REQ_REFRESH   = 2'd1;
  localparam logic [1:0] REQ_INIT      = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_LATCH = 2'd1;
  localparam logic [1:0] KIND_BANK  = 2'd2;

  // Color slot within a pixel word {red, green, blue}
  localparam logic [1:0] COMP_BLUE  = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_RED   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REFRESH,
    S_LATCH,
    S_INIT,
    S_BANK
  } state_t;

  // Frame store write transaction
  typedef struct packed {
    logic              en;
    logic [PIX_AW-1:0] addr;
    logic [23:0]       data;
  } wr_req_t;

  // Frame store read transaction
  typedef struct packed {
    logic              en;
    logic [PIX_AW-1:0] addr;
  } rd_req_t;

  // Pixel word address: column-major, one word per pixel
  function automatic logic [PIX_AW-1:0] pix_addr(logic [2:0] col, logic [2:0] row);
    logic [PIX_AW+7:0] full;
    full = (PIX_AW + 8)'(col) * (PIX_AW + 8)'(MATRIX_ROWS) + (PIX_AW + 8)'(row);
    return full[PIX_AW-1:0];
  endfunction

  function automatic logic col_in_range(logic [2:0] col);
    return 32'(col) < 32'(MATRIX_COLUMNS);
  endfunction

  function automatic logic row_in_range(logic [2:0] row);
    return 32'(row) < 32'(MATRIX_ROWS);
  endfunction

endpackage

### src/lmls_frame_store.sv
module lmls_frame_store
  import lmls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  wr_req_t     wr,
  input  rd_req_t     rd,
  output logic [23:0] rd_pixel
);

  logic [23:0]       mem [PIXELS];
  logic [PIXELS-1:0] written;
  logic [23:0]       rd_data;
  logic              rd_hit;

  // Pixel memory, one 24-bit word per pixel
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

  // Per-pixel written flags give the cleared frame after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_hit <= written[rd.addr];
      end
    end
  end

  assign rd_pixel = rd_hit ? rd_data : 24'd0;

endmodule

### src/led_matrix_line_scanner.sv
// Line scanner for an 8x8 RGB LED matrix behind a constant-current
// shift-register driver.
//
// Requests: start with req_type, x, y, red, green, blue; a transaction is
// taken on a rising edge with start high and busy low.
//   set pixel : writes the pixel word, no result, busy stays low.
//   refresh   : 25 results on consecutive cycles starting the cycle after
//               the request (24 bytes blue/green/red for rows 0..7, then the
//               latch with the one-hot row enable); busy through the latch.
//   init      : 19 results starting the cycle after the request (18 bytes
//               of ones, then the bank switch); busy through the bank switch.
// Results: strobe marks each result for exactly one cycle; last marks the
// final one. The receiver cannot hold results off, so no stall exists.
// Rate: one result per cycle, set by the single result port; the frame store
// read for the next row is issued while the current row's three bytes go out.
// Reset: clears the frame store through per-pixel written flags, deselects
// the level bank and asserts the driver reset flag; no clearing pass needed.
module led_matrix_line_scanner
  import lmls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [2:0] x,
  input  logic [2:0] y,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       strobe,
  output logic [1:0] kind,
  output logic [7:0] serial_byte,
  output logic [7:0] row_enable,
  output logic       bank_select,
  output logic       driver_reset_released,
  output logic       last
);

  state_t      state, state_next;
  logic [2:0]  row, row_next;
  logic [1:0]  comp, comp_next;
  logic [4:0]  init_cnt, init_cnt_next;
  logic [2:0]  col, col_next;
  logic        col_ok, col_ok_next;
  logic        level_bank, level_bank_next;
  logic        released, released_next;
  logic        accept;
  wr_req_t     wr;
  rd_req_t     rd;
  logic [23:0] rd_pixel;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  lmls_frame_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd       (rd),
    .rd_pixel (rd_pixel)
  );

  // Set-pixel write
  always_comb begin
    wr.en   = accept && (req_type == REQ_SET_PIXEL) && col_in_range(x) && row_in_range(y);
    wr.addr = pix_addr(x, y);
    wr.data = {red, green, blue};
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row        <= '0;
      comp       <= COMP_BLUE;
      init_cnt   <= '0;
      col        <= '0;
      col_ok     <= 1'b0;
      level_bank <= 1'b0;
      released   <= 1'b0;
    end else begin
      state      <= state_next;
      row        <= row_next;
      comp       <= comp_next;
      init_cnt   <= init_cnt_next;
      col        <= col_next;
      col_ok     <= col_ok_next;
      level_bank <= level_bank_next;
      released   <= released_next;
    end
  end

  // Sequencer: next state, store reads and result fields
  always_comb begin
    state_next            = state;
    row_next              = row;
    comp_next             = comp;
    init_cnt_next         = init_cnt;
    col_next              = col;
    col_ok_next           = col_ok;
    level_bank_next       = level_bank;
    released_next         = released;
    rd.en                 = 1'b0;
    rd.addr               = pix_addr(col, row + 3'd1);
    strobe                = 1'b0;
    kind                  = KIND_DATA;
    serial_byte           = 8'd0;
    row_enable            = 8'd0;
    bank_select           = level_bank;
    driver_reset_released = released;
    last                  = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_REFRESH) begin
          col_next    = x;
          col_ok_next = col_in_range(x);
          row_next    = 3'd0;
          comp_next   = COMP_BLUE;
          rd.en       = 1'b1;
          rd.addr     = pix_addr(x, 3'd0);
          state_next  = S_REFRESH;
        end else if (accept && req_type == REQ_INIT) begin
          released_next   = 1'b1;
          level_bank_next = 1'b0;
          init_cnt_next   = 5'd0;
          state_next      = S_INIT;
        end
      end

      S_REFRESH: begin
        strobe = 1'b1;
        if (col_ok) begin
          case (comp)
            COMP_BLUE:  serial_byte = rd_pixel[7:0];
            COMP_GREEN: serial_byte = rd_pixel[15:8];
            COMP_RED:   serial_byte = rd_pixel[23:16];
            default:    serial_byte = 8'd0;
          endcase
        end
        if (comp == COMP_RED) begin
          comp_next = COMP_BLUE;
          if (row == ROW_LAST) begin
            state_next = S_LATCH;
          end else begin
            row_next = row + 3'd1;
            rd.en    = 1'b1;
          end
        end else begin
          comp_next = comp + 2'd1;
        end
      end

      S_LATCH: begin
        strobe     = 1'b1;
        kind       = KIND_LATCH;
        row_enable = col_ok ? (8'd1 << col) : 8'd0;
        last       = 1'b1;
        state_next = S_IDLE;
      end

      S_INIT: begin
        strobe      = 1'b1;
        serial_byte = ALL_ONES;
        if (init_cnt == INIT_LAST) begin
          state_next = S_BANK;
        end else begin
          init_cnt_next = init_cnt + 5'd1;
        end
      end

      S_BANK: begin
        strobe          = 1'b1;
        kind            = KIND_BANK;
        bank_select     = 1'b1;
        last            = 1'b1;
        level_bank_next = 1'b1;
        state_next      = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Checks
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy)
    else $error("block still busy after final result");

  a_row_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(row_enable))
    else $error("row enable not one-hot");

  a_refresh_starts: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_REFRESH || req_type == REQ_INIT) |=> strobe)
    else $error("first result missing after request");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !strobe)
    else $error("result while idle");

endmodule
